// File: design/rtb_pkg.sv
// Shared types and mode codes of the tinted RGB565 blender.
package rtb_pkg;

	localparam logic [2:0] MODE_SET = 3'd0;
	localparam logic [2:0] MODE_MIX = 3'd1;
	localparam logic [2:0] MODE_ADD = 3'd2;
	localparam logic [2:0] MODE_SUB = 3'd3;
	localparam logic [2:0] MODE_MUL = 3'd4;

	localparam logic [2:0] REG_BLEND_MODE = 3'd0;
	localparam logic [2:0] REG_TINT_RED   = 3'd1;
	localparam logic [2:0] REG_TINT_GREEN = 3'd2;
	localparam logic [2:0] REG_TINT_BLUE  = 3'd3;
	localparam logic [2:0] REG_TINT_ALPHA = 3'd4;

	localparam logic [5:0] MAX5 = 6'h1F;
	localparam logic [5:0] MAX6 = 6'h3F;
	localparam logic [8:0] WEIGHT_SUM = 9'd257;

	typedef struct packed {
		logic [5:0] d;
		logic [5:0] s;
	} chan_t;

	typedef struct packed {
		logic [5:0]  d;
		logic [5:0]  s;
		logic [13:0] dst_w;
		logic [13:0] src_w;
		logic [11:0] mul;
	} prod_t;

endpackage

// File: design/rtb_prep.sv
// Unpack the destination, tint the source channels and form the mix weights.
module rtb_prep (
	input  logic [15:0]         dst_pixel,
	input  logic [7:0]          src_red,
	input  logic [7:0]          src_green,
	input  logic [7:0]          src_blue,
	input  logic [7:0]          src_alpha,
	input  logic [7:0]          tint_red,
	input  logic [7:0]          tint_green,
	input  logic [7:0]          tint_blue,
	input  logic [7:0]          tint_alpha,
	output rtb_pkg::chan_t      red,
	output rtb_pkg::chan_t      green,
	output rtb_pkg::chan_t      blue,
	output logic [8:0]          src_weight,
	output logic [8:0]          dst_weight
);
	import rtb_pkg::*;

	logic [5:0]  tr, tb;
	logic [6:0]  tg;
	logic [10:0] pr, pb;
	logic [11:0] pg;
	logic [8:0]  ta;
	logic [16:0] pa;

	always_comb begin
		tr = {1'b0, tint_red[7:3]} + 6'd1;
		tb = {1'b0, tint_blue[7:3]} + 6'd1;
		tg = {1'b0, tint_green[7:2]} + 7'd1;
		pr = 11'(src_red[7:3] * tr);
		pb = 11'(src_blue[7:3] * tb);
		pg = 12'(src_green[7:2] * tg);
		ta = {1'b0, tint_alpha} + 9'd1;
		pa = 17'(src_alpha * ta);
		red.d   = {1'b0, dst_pixel[15:11]};
		red.s   = {1'b0, pr[9:5]};
		green.d = dst_pixel[10:5];
		green.s = pg[11:6];
		blue.d  = {1'b0, dst_pixel[4:0]};
		blue.s  = {1'b0, pb[9:5]};
		src_weight = {1'b0, pa[15:8]} + 9'd1;
		dst_weight = WEIGHT_SUM - src_weight;
	end

endmodule

// File: design/rtb_chan_prod.sv
// Form the per-channel products for mix and multiply.
module rtb_chan_prod (
	input  rtb_pkg::chan_t chan,
	input  logic [8:0]     src_weight,
	input  logic [8:0]     dst_weight,
	output rtb_pkg::prod_t prod
);
	import rtb_pkg::*;

	logic [6:0] s_inc;

	always_comb begin
		s_inc      = {1'b0, chan.s} + 7'd1;
		prod.d     = chan.d;
		prod.s     = chan.s;
		prod.dst_w = 14'(chan.d * dst_weight);
		prod.src_w = 14'(chan.s * src_weight);
		prod.mul   = 12'(chan.d * s_inc);
	end

endmodule

// File: design/rtb_chan_comb.sv
// Combine one channel under the blend mode.
module rtb_chan_comb (
	input  rtb_pkg::prod_t prod,
	input  logic [2:0]     mode,
	input  logic           wide,
	output logic [5:0]     value
);
	import rtb_pkg::*;

	logic [5:0]  cmax;
	logic [14:0] mix_sum;
	logic [6:0]  add_sum;
	logic [5:0]  mul_val;

	always_comb begin
		cmax    = wide ? MAX6 : MAX5;
		mix_sum = {1'b0, prod.dst_w} + {1'b0, prod.src_w};
		add_sum = {1'b0, prod.d} + {1'b0, prod.s};
		mul_val = wide ? prod.mul[11:6] : {1'b0, prod.mul[9:5]};
		unique case (mode)
			MODE_SET: value = prod.s;
			MODE_MIX: value = mix_sum[13:8] & cmax;
			MODE_ADD: value = (add_sum > {1'b0, cmax}) ? cmax : add_sum[5:0];
			MODE_SUB: value = (prod.d > prod.s) ? prod.d - prod.s : 6'd0;
			MODE_MUL: value = mul_val & cmax;
			default:  value = prod.d;
		endcase
	end

endmodule

// File: design/rgb565_tinted_blend_core.sv
// Top level of the tinted RGB565 blender: config registers and three-stage pipeline.
// Takes one pixel per clock while in_ready is high. A result passes through the stage 1,
// stage 2 and stage 3 registers and leaves once the output accepts it. Stage 1 tints the source and
// forms the alpha weights, stage 2 forms the channel products, and stage 3 combines them
// under the blend mode into the output register. Ready is combinational back to the input,
// so a stalled output holds only the stages behind it that are full, and bubbles close up.
// Write configuration only while the pipeline is empty.
module rgb565_tinted_blend_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] dst_pixel,
	input  logic [7:0]  src_red,
	input  logic [7:0]  src_green,
	input  logic [7:0]  src_blue,
	input  logic [7:0]  src_alpha,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_pixel
);
	import rtb_pkg::*;

	logic [2:0] blend_mode_q;
	logic [7:0] tint_red_q, tint_green_q, tint_blue_q, tint_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= MODE_SET;
			tint_red_q   <= 8'hFF;
			tint_green_q <= 8'hFF;
			tint_blue_q  <= 8'hFF;
			tint_alpha_q <= 8'hFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLEND_MODE: blend_mode_q <= cfg_data[2:0];
				REG_TINT_RED:   tint_red_q   <= cfg_data;
				REG_TINT_GREEN: tint_green_q <= cfg_data;
				REG_TINT_BLUE:  tint_blue_q  <= cfg_data;
				REG_TINT_ALPHA: tint_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3 = !v_s3 || out_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	chan_t      r_c, g_c, b_c;
	logic [8:0] sw_c, dw_c;

	rtb_prep u_prep (
		.dst_pixel  (dst_pixel),
		.src_red    (src_red),
		.src_green  (src_green),
		.src_blue   (src_blue),
		.src_alpha  (src_alpha),
		.tint_red   (tint_red_q),
		.tint_green (tint_green_q),
		.tint_blue  (tint_blue_q),
		.tint_alpha (tint_alpha_q),
		.red        (r_c),
		.green      (g_c),
		.blue       (b_c),
		.src_weight (sw_c),
		.dst_weight (dw_c)
	);

	chan_t      r_s1, g_s1, b_s1;
	logic [8:0] sw_s1, dw_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			r_s1  <= r_c;
			g_s1  <= g_c;
			b_s1  <= b_c;
			sw_s1 <= sw_c;
			dw_s1 <= dw_c;
		end
	end

	prod_t r_p, g_p, b_p;

	rtb_chan_prod u_prod_r (.chan(r_s1), .src_weight(sw_s1), .dst_weight(dw_s1), .prod(r_p));
	rtb_chan_prod u_prod_g (.chan(g_s1), .src_weight(sw_s1), .dst_weight(dw_s1), .prod(g_p));
	rtb_chan_prod u_prod_b (.chan(b_s1), .src_weight(sw_s1), .dst_weight(dw_s1), .prod(b_p));

	prod_t r_s2, g_s2, b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			r_s2 <= r_p;
			g_s2 <= g_p;
			b_s2 <= b_p;
		end
	end

	logic [5:0] r_v, g_v, b_v;

	rtb_chan_comb u_comb_r (.prod(r_s2), .mode(blend_mode_q), .wide(1'b0), .value(r_v));
	rtb_chan_comb u_comb_g (.prod(g_s2), .mode(blend_mode_q), .wide(1'b1), .value(g_v));
	rtb_chan_comb u_comb_b (.prod(b_s2), .mode(blend_mode_q), .wide(1'b0), .value(b_v));

	logic [15:0] pixel_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			pixel_s3 <= {r_v[4:0], g_v, b_v[4:0]};
		end
	end

	assign out_valid    = v_s3;
	assign result_pixel = pixel_s3;

	a_adv_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && ready_s2 |=> v_s2)
		else $error("stage 1 request lost on advance");

	a_adv_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && ready_s3 |=> v_s3)
		else $error("stage 2 request lost on advance");

	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !ready_s3 |=> v_s2 && v_s3)
		else $error("stalled stage 2 request dropped");

endmodule
